### rtl/core/ring_line_buffer_macros.svh
// assertion macros used by the ring line buffer checker
`ifndef RING_LINE_BUFFER_MACROS_SVH
`define RING_LINE_BUFFER_MACROS_SVH

// consequent checked in the same cycle
`define RLB_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define RLB_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/rlb_pkg.sv
// shared types, constants and position helpers of the ring line buffer
package rlb_pkg;

   localparam int RLB_DEPTH = 64;
   localparam int LEN_W = 7;
   localparam int BYTE_W = 8;
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(3);
   localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd10;
   localparam logic [LEN_W-1:0] RING_LEN_RESET = 7'd64;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic CSR_DELIMITER = 1'b0;
   localparam logic CSR_RING_LENGTH = 1'b1;

   typedef enum logic [1:0] {
      STATUS_BYTE = 2'd0,
      STATUS_NO_LINE = 2'd1,
      STATUS_EMPTY_LINE = 2'd2
   } line_status_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_EMIT
   } eng_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] delimiter;
      logic [LEN_W-1:0] ring_length;
   } cfg_type;

   typedef struct packed {
      logic is_read;
      logic [BYTE_W-1:0] data;
   } cmd_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] line_byte;
      line_status_type line_status;
      logic last_of_line;
   } rsp_item_type;

   typedef struct packed {
      logic push;
      rsp_item_type item;
   } rsp_push_type;

   // position used as is, or 0 once it sits at or past the wrap
   function automatic logic [LEN_W-1:0] norm_pos(input logic [LEN_W-1:0] p,
                                                 input logic [LEN_W-1:0] l);
      return ((p + LEN_W'(1)) >= l) ? '0 : p;
   endfunction

   function automatic logic [LEN_W-1:0] next_pos(input logic [LEN_W-1:0] p,
                                                 input logic [LEN_W-1:0] l);
      return ((p + LEN_W'(1)) >= l) ? '0 : p + LEN_W'(1);
   endfunction

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] l,
                                                  input logic [LEN_W-1:0] top);
      logic [LEN_W-1:0] r;
      r = l;
      if (r < MIN_LEN) r = MIN_LEN;
      if (r > top) r = top;
      return r;
   endfunction

endpackage

### rtl/core/rlb_front.sv
// front end: takes requests, drops zero writes, queues commands for the engine
module rlb_front import rlb_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic req_type,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic cmd_valid,
   input  logic cmd_pop,
   output cmd_item_type cmd
);

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_item_type q_ff [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic accept;
   logic store;
   logic take;

   assign full = (cnt_ff == CNT_W'(CMD_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd = q_ff[rd_ptr_ff];
   assign accept = push && !full;
   // a zero write changes nothing, so it never reaches the engine
   assign store = accept && ((req_type == REQ_READ) || (req_data_byte != '0));
   assign take = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (store) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      cnt_in = cnt_ff + CNT_W'(store) - CNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         q_ff[wr_ptr_ff] <= '{is_read: req_type, data: req_data_byte};
      end
   end

endmodule

### rtl/core/rlb_engine.sv
// back end: byte ring memory, line scan and line emission
module rlb_engine import rlb_pkg::*; #(
   parameter int DEPTH = RLB_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic cmd_valid,
   output logic cmd_pop,
   input  cmd_item_type cmd,
   input  logic [RSP_CNT_W-1:0] rsp_count,
   output rsp_push_type rsp
);

   localparam int PTR_W = $clog2(DEPTH);

   eng_state_type state_ff, state_in;
   logic [PTR_W-1:0] read_pos_ff, read_pos_in;
   logic [PTR_W-1:0] write_pos_ff, write_pos_in;
   logic [PTR_W-1:0] start_ff, start_in;
   logic [PTR_W-1:0] walk_ff, walk_in;
   logic [LEN_W-1:0] issued_ff, issued_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic scan_vld_ff, scan_vld_in;
   logic emit_vld_ff, emit_vld_in;
   logic emit_last_ff, emit_last_in;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [BYTE_W-1:0] mem_q_ff;
   logic vq_ff;

   logic rd_en;
   logic [PTR_W-1:0] rd_addr;
   logic wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic clr_en;
   logic [PTR_W-1:0] clr_addr;

   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] lap;
   logic [BYTE_W-1:0] rd_byte;
   logic done;

   assign len = clamp_len(cfg.ring_length, LEN_W'(DEPTH));
   assign lap = len - LEN_W'(1);
   assign rd_byte = vq_ff ? mem_q_ff : '0;

   always_comb begin
      state_in = state_ff;
      read_pos_in = read_pos_ff;
      write_pos_in = write_pos_ff;
      start_in = start_ff;
      walk_in = walk_ff;
      issued_in = issued_ff;
      count_in = count_ff;
      left_in = left_ff;
      scan_vld_in = 1'b0;
      emit_vld_in = 1'b0;
      emit_last_in = emit_last_ff;
      cmd_pop = 1'b0;
      rd_en = 1'b0;
      rd_addr = walk_ff;
      wr_en = 1'b0;
      wr_addr = PTR_W'(norm_pos(LEN_W'(write_pos_ff), len));
      clr_en = 1'b0;
      clr_addr = walk_ff;
      rsp = '0;
      done = 1'b0;
      case (state_ff)
         ENG_IDLE: begin
            if (cmd_valid) begin
               if (!cmd.is_read) begin
                  cmd_pop = 1'b1;
                  wr_en = 1'b1;
                  write_pos_in = PTR_W'(next_pos(LEN_W'(wr_addr), len));
               end else if (rsp_count < RSP_CNT_W'(RSP_DEPTH)) begin
                  cmd_pop = 1'b1;
                  start_in = PTR_W'(norm_pos(LEN_W'(read_pos_ff), len));
                  walk_in = start_in;
                  issued_in = '0;
                  count_in = '0;
                  state_in = ENG_SCAN;
               end
            end
         end
         ENG_SCAN: begin
            if (scan_vld_ff) begin
               if (rd_byte == '0) begin
                  done = 1'b1;
                  rsp.push = 1'b1;
                  rsp.item = '{line_byte: '0, line_status: STATUS_NO_LINE, last_of_line: 1'b1};
                  state_in = ENG_IDLE;
               end else if (rd_byte == cfg.delimiter) begin
                  done = 1'b1;
                  if (count_ff == '0) begin
                     clr_en = 1'b1;
                     clr_addr = start_ff;
                     read_pos_in = PTR_W'(next_pos(LEN_W'(start_ff), len));
                     rsp.push = 1'b1;
                     rsp.item = '{line_byte: '0, line_status: STATUS_EMPTY_LINE,
                                  last_of_line: 1'b1};
                     state_in = ENG_IDLE;
                  end else begin
                     walk_in = start_ff;
                     left_in = count_ff;
                     state_in = ENG_EMIT;
                  end
               end else begin
                  count_in = count_ff + LEN_W'(1);
                  // a whole lap without the delimiter
                  if (count_in >= lap) begin
                     done = 1'b1;
                     rsp.push = 1'b1;
                     rsp.item = '{line_byte: '0, line_status: STATUS_NO_LINE,
                                  last_of_line: 1'b1};
                     state_in = ENG_IDLE;
                  end
               end
            end
            // reads are issued one per cycle ahead of the compare
            if (!done && (issued_ff < lap)) begin
               rd_en = 1'b1;
               rd_addr = walk_ff;
               walk_in = PTR_W'(next_pos(LEN_W'(walk_ff), len));
               issued_in = issued_ff + LEN_W'(1);
               scan_vld_in = 1'b1;
            end
         end
         ENG_EMIT: begin
            if (emit_vld_ff) begin
               rsp.push = 1'b1;
               rsp.item = '{line_byte: rd_byte, line_status: STATUS_BYTE,
                            last_of_line: emit_last_ff};
            end
            if (left_ff != '0) begin
               // keep room in the result queue for the byte still in flight
               if ((rsp_count + RSP_CNT_W'(emit_vld_ff)) < RSP_CNT_W'(RSP_DEPTH)) begin
                  rd_en = 1'b1;
                  rd_addr = walk_ff;
                  clr_en = 1'b1;
                  clr_addr = walk_ff;
                  walk_in = PTR_W'(next_pos(LEN_W'(walk_ff), len));
                  left_in = left_ff - LEN_W'(1);
                  emit_vld_in = 1'b1;
                  emit_last_in = (left_ff == LEN_W'(1));
               end
            end else begin
               // walk now points at the delimiter
               clr_en = 1'b1;
               clr_addr = walk_ff;
               read_pos_in = PTR_W'(next_pos(LEN_W'(walk_ff), len));
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         read_pos_ff <= '0;
         write_pos_ff <= '0;
         scan_vld_ff <= 1'b0;
         emit_vld_ff <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         read_pos_ff <= read_pos_in;
         write_pos_ff <= write_pos_in;
         scan_vld_ff <= scan_vld_in;
         emit_vld_ff <= emit_vld_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (clr_en) begin
            valid_ff[clr_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      walk_ff <= walk_in;
      issued_ff <= issued_in;
      count_ff <= count_in;
      left_ff <= left_in;
      emit_last_ff <= emit_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
         vq_ff <= valid_ff[rd_addr];
      end
   end

endmodule

### rtl/core/rlb_rsp_fifo.sv
// result queue between the engine and the result ports
module rlb_rsp_fifo import rlb_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  rsp_push_type rsp,
   output logic [RSP_CNT_W-1:0] count,
   output logic empty,
   input  logic pop,
   output rsp_item_type head
);

   localparam int PTR_W = $clog2(RSP_DEPTH);

   rsp_item_type q_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic take;

   assign count = cnt_ff;
   assign empty = (cnt_ff == '0);
   assign head = q_ff[rd_ptr_ff];
   assign take = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (rsp.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      cnt_in = cnt_ff + RSP_CNT_W'(rsp.push) - RSP_CNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp.push) begin
         q_ff[wr_ptr_ff] <= rsp.item;
      end
   end

endmodule

### rtl/core/ring_line_buffer.sv
// Ring line buffer: bytes pushed one per cycle while full is low land in a ring of up to DEPTH
// slots; a read request scans from the read position for the delimiter and returns the line
// one byte per result, or a single status result. A write is done by the engine while it is
// idle, so writes stream at one per cycle through the two-entry command queue when no read
// is in progress. A read scans with one memory read per cycle, each compared in the cycle
// after, then emits the line bytes, slowed only when the four-entry result queue is not
// drained. A read is started only while the result queue has a free entry. No clearing
// pass runs after reset: each slot has a valid flag.
module ring_line_buffer import rlb_pkg::*; #(
   parameter int DEPTH = RLB_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic req_type,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic empty,
   input  logic pop,
   output logic [BYTE_W-1:0] rsp_line_byte,
   output logic [1:0] rsp_line_status,
   output logic rsp_last_of_line,
   input  logic valid,
   output logic ready,
   input  logic csr_index,
   input  logic [BYTE_W-1:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic cmd_valid;
   logic cmd_pop;
   cmd_item_type cmd;
   rsp_push_type rsp;
   logic [RSP_CNT_W-1:0] rsp_count;
   rsp_item_type head;

   assign ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (valid) begin
         case (csr_index)
            CSR_DELIMITER: cfg_in.delimiter = csr_data[BYTE_W-1:0];
            CSR_RING_LENGTH: cfg_in.ring_length = csr_data[LEN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{delimiter: DELIM_RESET, ring_length: RING_LEN_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rlb_front u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_type(req_type),
      .req_data_byte(req_data_byte),
      .cmd_valid(cmd_valid),
      .cmd_pop(cmd_pop),
      .cmd(cmd)
   );

   rlb_engine #(.DEPTH(DEPTH)) u_engine (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .cmd_valid(cmd_valid),
      .cmd_pop(cmd_pop),
      .cmd(cmd),
      .rsp_count(rsp_count),
      .rsp(rsp)
   );

   rlb_rsp_fifo u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .rsp(rsp),
      .count(rsp_count),
      .empty(empty),
      .pop(pop),
      .head(head)
   );

   assign rsp_line_byte = head.line_byte;
   assign rsp_line_status = head.line_status;
   assign rsp_last_of_line = head.last_of_line;

endmodule

### rtl/core/rlb_checker.sv
// port-level checks of the ring line buffer and their bind
`include "ring_line_buffer_macros.svh"

module rlb_checker import rlb_pkg::*; (
   input logic clock,
   input logic reset,
   input logic full,
   input logic empty,
   input logic pop,
   input logic [BYTE_W-1:0] rsp_line_byte,
   input logic [1:0] rsp_line_status,
   input logic rsp_last_of_line
);

   `RLB_ASSERT_SAME(a_reset_idle, clock, reset, $fell(reset), empty && !full,
      "not idle after reset")
   `RLB_ASSERT_SAME(a_status_last, clock, reset,
      !empty && (rsp_line_status != STATUS_BYTE), rsp_last_of_line,
      "status result without last mark")
   `RLB_ASSERT_SAME(a_byte_nonzero, clock, reset, !empty,
      (rsp_line_status == STATUS_BYTE) == (rsp_line_byte != '0),
      "line byte and status disagree")
   `RLB_ASSERT_NEXT(a_head_hold, clock, reset, !empty && !pop,
      !empty && $stable(rsp_line_byte) && $stable(rsp_line_status) &&
      $stable(rsp_last_of_line), "waiting result changed")

endmodule

bind ring_line_buffer rlb_checker u_rlb_checker (
   .clock(clock),
   .reset(reset),
   .full(full),
   .empty(empty),
   .pop(pop),
   .rsp_line_byte(rsp_line_byte),
   .rsp_line_status(rsp_line_status),
   .rsp_last_of_line(rsp_last_of_line)
);
